/* sv/tree_lca_climb_engine_defines.svh */
// Assertion macros used by the checker file.
`ifndef TREE_LCA_CLIMB_ENGINE_DEFINES_SVH
`define TREE_LCA_CLIMB_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LCA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define LCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define LCA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* sv/lca_pkg.sv */
// Types and constants of the tree ancestor engine.
package lca_pkg;

   localparam int VERT_W       = 10;
   localparam int EDGE_W       = 11;
   localparam int MAX_VERTICES = 1024;
   localparam int MAX_EDGES    = 2 * (MAX_VERTICES - 1);
   localparam logic [EDGE_W-1:0] NO_EDGE     = EDGE_W'(MAX_EDGES);
   localparam logic [VERT_W-1:0] ROOT_VERTEX = VERT_W'(1);

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_BUILD  = 2'd1,
      FUNC_QUERY  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ERR_OK      = 2'd0,
      ERR_BAD     = 2'd1,
      ERR_FULL    = 2'd2,
      ERR_NOTREE  = 2'd3
   } err_type;

   typedef enum logic [4:0] {
      ST_RST_CLR,
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WR,
      ST_INS_LINK,
      ST_BLD_CLR,
      ST_BLD_ROOT,
      ST_BLD_POP,
      ST_BLD_HEAD,
      ST_BLD_EDGE,
      ST_BLD_TGT,
      ST_BLD_VIS,
      ST_QRY_RA,
      ST_QRY_RB,
      ST_QRY_CHK,
      ST_QRY_LOOP,
      ST_QRY_STEP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [EDGE_W-1:0] head;
      logic [EDGE_W-1:0] tail;
   } list_type;

   typedef struct packed {
      logic              vis;
      logic [VERT_W-1:0] par;
      logic [VERT_W-1:0] dep;
   } node_type;

endpackage

/* sv/lca_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
module lca_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/tree_lca_climb_engine.sv */
// Insert appends to both lists; build clears nodes, then walks breadth-first from the root.
// Query climbs one step at a time, bounded by the node store's single read port.
// One item in flight; a result waits in an output register while the next is taken.
// Synchronous reset starts a pass that empties the list and node stores;
// req_tready stays low until it ends. Each build repeats the node-store pass.
module tree_lca_climb_engine
   import lca_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [9:0] first_vertex, [19:10] second_vertex, pad
   input  logic [1:0]  req_tuser,  // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // [9:0] ancestor, [11:10] error, pad
);

   localparam int VA_W = $clog2(MAX_VERTICES);
   localparam int EA_W = $clog2(MAX_EDGES);

   state_type state_ff, state_in;
   logic [VA_W-1:0]   cnt_ff, cnt_in;
   logic [VERT_W-1:0] fa_ff, fa_in, fb_ff, fb_in;
   logic              side_ff, side_in;
   logic [EDGE_W-1:0] ecount_ff, ecount_in;
   logic [EDGE_W-1:0] tail_ff, tail_in, e_ff, e_in;
   logic [VERT_W-1:0] v_ff, v_in, vdep_ff, vdep_in;
   logic [VERT_W:0]   qhead_ff, qhead_in, qtail_ff, qtail_in;
   logic [VERT_W-1:0] qa_ff, qa_in, qb_ff, qb_in;
   logic [VERT_W-1:0] da_ff, da_in, db_ff, db_in;
   logic [VERT_W-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic              va_ff, va_in;
   logic [VERT_W-1:0] anc_ff, anc_in;
   err_type           err_ff, err_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;

   logic              list_we;
   logic [VA_W-1:0]   list_wa, list_ra;
   list_type          list_wd, list_rd;
   logic              node_we;
   logic [VA_W-1:0]   node_wa, node_ra;
   node_type          node_wd, node_rd;
   logic              tgt_we;
   logic [EA_W-1:0]   tgt_wa, tgt_ra;
   logic [VERT_W-1:0] tgt_wd, tgt_rd;
   logic              nxt_we;
   logic [EA_W-1:0]   nxt_wa, nxt_ra;
   logic [EDGE_W-1:0] nxt_wd, nxt_rd;
   logic              que_we;
   logic [VA_W-1:0]   que_wa, que_ra;
   logic [VERT_W-1:0] que_wd, que_rd;

   logic              accept;
   logic [VERT_W-1:0] req_a, req_b, cur_from, cur_to;
   logic              req_ok;

   lca_ram #(.DEPTH(MAX_VERTICES), .WIDTH($bits(list_type))) u_list (
      .clock, .wr_en(list_we), .wr_addr(list_wa), .wr_data(list_wd),
      .rd_addr(list_ra), .rd_data(list_rd));
   lca_ram #(.DEPTH(MAX_VERTICES), .WIDTH($bits(node_type))) u_node (
      .clock, .wr_en(node_we), .wr_addr(node_wa), .wr_data(node_wd),
      .rd_addr(node_ra), .rd_data(node_rd));
   lca_ram #(.DEPTH(MAX_EDGES), .WIDTH(VERT_W)) u_tgt (
      .clock, .wr_en(tgt_we), .wr_addr(tgt_wa), .wr_data(tgt_wd),
      .rd_addr(tgt_ra), .rd_data(tgt_rd));
   lca_ram #(.DEPTH(MAX_EDGES), .WIDTH(EDGE_W)) u_nxt (
      .clock, .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_addr(nxt_ra), .rd_data(nxt_rd));
   lca_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VERT_W)) u_que (
      .clock, .wr_en(que_we), .wr_addr(que_wa), .wr_data(que_wd),
      .rd_addr(que_ra), .rd_data(que_rd));

   assign req_a      = req_tdata[9:0];
   assign req_b      = req_tdata[19:10];
   assign req_ok     = (req_a != '0) && (req_b != '0);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign cur_from   = side_ff ? fb_ff : fa_ff;
   assign cur_to     = side_ff ? fa_ff : fb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RST_CLR;
         cnt_ff       <= '0;
         ecount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ecount_ff    <= ecount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fa_ff       <= fa_in;
      fb_ff       <= fb_in;
      side_ff     <= side_in;
      tail_ff     <= tail_in;
      e_ff        <= e_in;
      v_ff        <= v_in;
      vdep_ff     <= vdep_in;
      qhead_ff    <= qhead_in;
      qtail_ff    <= qtail_in;
      qa_ff       <= qa_in;
      qb_ff       <= qb_in;
      da_ff       <= da_in;
      db_ff       <= db_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      va_ff       <= va_in;
      anc_ff      <= anc_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fa_in        = fa_ff;
      fb_in        = fb_ff;
      side_in      = side_ff;
      ecount_in    = ecount_ff;
      tail_in      = tail_ff;
      e_in         = e_ff;
      v_in         = v_ff;
      vdep_in      = vdep_ff;
      qhead_in     = qhead_ff;
      qtail_in     = qtail_ff;
      qa_in        = qa_ff;
      qb_in        = qb_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      va_in        = va_ff;
      anc_in       = anc_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      list_we = 1'b0;  list_wa = '0;  list_wd = '0;  list_ra = '0;
      node_we = 1'b0;  node_wa = '0;  node_wd = '0;  node_ra = '0;
      tgt_we  = 1'b0;  tgt_wa  = '0;  tgt_wd  = '0;  tgt_ra  = '0;
      nxt_we  = 1'b0;  nxt_wa  = '0;  nxt_wd  = '0;  nxt_ra  = '0;
      que_we  = 1'b0;  que_wa  = '0;  que_wd  = '0;  que_ra  = '0;

      unique case (state_ff)
         ST_RST_CLR: begin
            list_we = 1'b1;
            list_wa = cnt_ff;
            list_wd = '{head: NO_EDGE, tail: NO_EDGE};
            node_we = 1'b1;
            node_wa = cnt_ff;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == VA_W'(MAX_VERTICES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               fa_in   = req_a;
               fb_in   = req_b;
               side_in = 1'b0;
               anc_in  = '0;
               err_in  = ERR_OK;
               cnt_in  = '0;
               unique case (func_type'(req_tuser))
                  FUNC_INSERT: begin
                     if (!req_ok) begin
                        err_in   = ERR_BAD;
                        state_in = ST_DONE;
                     end else if (({1'b0, ecount_ff} + 12'd2) > 12'(MAX_EDGES)) begin
                        err_in   = ERR_FULL;
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_INS_RD;
                     end
                  end
                  FUNC_BUILD: state_in = ST_BLD_CLR;
                  FUNC_QUERY: begin
                     if (!req_ok) begin
                        err_in   = ERR_BAD;
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_QRY_RA;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_INS_RD: begin
            list_ra  = cur_from;
            state_in = ST_INS_WR;
         end
         ST_INS_WR: begin
            // append the new entry at the list tail
            tgt_we    = 1'b1;
            tgt_wa    = ecount_ff;
            tgt_wd    = cur_to;
            nxt_we    = 1'b1;
            nxt_wa    = ecount_ff;
            nxt_wd    = NO_EDGE;
            list_we   = 1'b1;
            list_wa   = cur_from;
            tail_in   = list_rd.tail;
            e_in      = ecount_ff;
            ecount_in = ecount_ff + 1'b1;
            if (list_rd.tail == NO_EDGE) begin
               list_wd = '{head: ecount_ff, tail: ecount_ff};
               side_in = 1'b1;
               state_in = side_ff ? ST_DONE : ST_INS_RD;
            end else begin
               list_wd  = '{head: list_rd.head, tail: ecount_ff};
               state_in = ST_INS_LINK;
            end
         end
         ST_INS_LINK: begin
            nxt_we   = 1'b1;
            nxt_wa   = tail_ff;
            nxt_wd   = e_ff;
            side_in  = 1'b1;
            state_in = side_ff ? ST_DONE : ST_INS_RD;
         end
         ST_BLD_CLR: begin
            node_we = 1'b1;
            node_wa = cnt_ff;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == VA_W'(MAX_VERTICES - 1)) begin
               state_in = ST_BLD_ROOT;
            end
         end
         ST_BLD_ROOT: begin
            node_we  = 1'b1;
            node_wa  = ROOT_VERTEX;
            node_wd  = '{vis: 1'b1, par: '0, dep: VERT_W'(1)};
            que_we   = 1'b1;
            que_wd   = ROOT_VERTEX;
            qhead_in = '0;
            qtail_in = (VERT_W+1)'(1);
            state_in = ST_BLD_POP;
         end
         ST_BLD_POP: begin
            if (qhead_ff == qtail_ff) begin
               state_in = ST_DONE;
            end else begin
               que_ra   = qhead_ff[VA_W-1:0];
               qhead_in = qhead_ff + 1'b1;
               state_in = ST_BLD_HEAD;
            end
         end
         ST_BLD_HEAD: begin
            v_in     = que_rd;
            list_ra  = que_rd;
            node_ra  = que_rd;
            state_in = ST_BLD_EDGE;
         end
         ST_BLD_EDGE: begin
            vdep_in = node_rd.dep;
            if (list_rd.head == NO_EDGE) begin
               state_in = ST_BLD_POP;
            end else begin
               tgt_ra   = list_rd.head;
               nxt_ra   = list_rd.head;
               state_in = ST_BLD_TGT;
            end
         end
         ST_BLD_TGT: begin
            fa_in    = tgt_rd;
            e_in     = nxt_rd;
            node_ra  = tgt_rd;
            state_in = ST_BLD_VIS;
         end
         ST_BLD_VIS: begin
            if (!node_rd.vis) begin
               node_we  = 1'b1;
               node_wa  = fa_ff;
               node_wd  = '{vis: 1'b1, par: v_ff, dep: vdep_ff + 1'b1};
               que_we   = 1'b1;
               que_wa   = qtail_ff[VA_W-1:0];
               que_wd   = fa_ff;
               qtail_in = qtail_ff + 1'b1;
            end
            if (e_ff == NO_EDGE) begin
               state_in = ST_BLD_POP;
            end else begin
               tgt_ra   = e_ff;
               nxt_ra   = e_ff;
               state_in = ST_BLD_TGT;
            end
         end
         ST_QRY_RA: begin
            node_ra  = fa_ff;
            state_in = ST_QRY_RB;
         end
         ST_QRY_RB: begin
            va_in    = node_rd.vis;
            da_in    = node_rd.dep;
            pa_in    = node_rd.par;
            node_ra  = fb_ff;
            state_in = ST_QRY_CHK;
         end
         ST_QRY_CHK: begin
            db_in = node_rd.dep;
            pb_in = node_rd.par;
            qa_in = fa_ff;
            qb_in = fb_ff;
            if (!va_ff || !node_rd.vis) begin
               err_in   = ERR_NOTREE;
               state_in = ST_DONE;
            end else begin
               state_in = ST_QRY_LOOP;
            end
         end
         ST_QRY_LOOP: begin
            // move the deeper side up, the first one on a tie
            if (qa_ff == qb_ff) begin
               anc_in   = qa_ff;
               state_in = ST_DONE;
            end else if (da_ff >= db_ff) begin
               qa_in    = pa_ff;
               node_ra  = pa_ff;
               side_in  = 1'b0;
               state_in = ST_QRY_STEP;
            end else begin
               qb_in    = pb_ff;
               node_ra  = pb_ff;
               side_in  = 1'b1;
               state_in = ST_QRY_STEP;
            end
         end
         ST_QRY_STEP: begin
            if (side_ff) begin
               db_in = node_rd.dep;
               pb_in = node_rd.par;
            end else begin
               da_in = node_rd.dep;
               pa_in = node_rd.par;
            end
            state_in = ST_QRY_LOOP;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, err_ff, anc_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* sv/lca_checker.sv */
// Port-level checks for the tree ancestor engine, bound to the top level.
`include "tree_lca_climb_engine_defines.svh"

module lca_checker
   import lca_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   logic req_beat;
   logic rsp_err;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_err  = (rsp_tdata[11:10] != ERR_OK);

   `LCA_ASSERT_IMPLY(a_err_no_anc, clock, reset, rsp_tvalid && rsp_err, rsp_tdata[9:0] == '0)
   `LCA_ASSERT_IMPLY(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[15:12] == '0)
   `LCA_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_beat, !req_tready)
   `LCA_ASSERT_NEXT_ALWAYS(a_clear_after_reset, clock, reset, !req_tready)
   `LCA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))

endmodule

bind tree_lca_climb_engine lca_checker u_lca_checker (
   .clock, .reset, .req_tvalid, .req_tready,
   .rsp_tvalid, .rsp_tready, .rsp_tdata
);
